// ----- rtl/boot_image_verifier_assert.svh -----
// Assertion macros for the boot image verifier.
// Used by boot_image_verifier.sv; compiled out when SYNTH is defined.
`ifndef BOOT_IMAGE_VERIFIER_ASSERT_SVH
`define BOOT_IMAGE_VERIFIER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define BIV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define BIV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BIV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BIV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/biv_pkg.sv -----
// Shared constants, register indexes and the byte-wide CRC-32 function
// for the boot image verifier. No dependencies.
`default_nettype none

package biv_pkg;

    localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PLACEHOLDER = 32'hAAAA_AAAA;

    // Item and verdict kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // Configuration register indexes (byte address is 4 times the index).
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_APP_START = 3'd0;
    localparam reg_idx_t REG_APP_END   = 3'd1;
    localparam reg_idx_t REG_SRAM_LOW  = 3'd2;
    localparam reg_idx_t REG_SRAM_HIGH = 3'd3;
    localparam reg_idx_t REG_MAGIC     = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [31:0] APP_START_RST = 32'h0800_8000;
    localparam logic [31:0] APP_END_RST   = 32'h0808_0000;
    localparam logic [31:0] SRAM_LOW_RST  = 32'h2000_0000;
    localparam logic [31:0] SRAM_HIGH_RST = 32'h2001_FFFF;
    localparam logic [31:0] MAGIC_RST     = 32'h0000_0000;

    // Reflected CRC-32 update by one byte, LSB first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/biv_in_if.sv -----
// Input channel of the boot image verifier: valid/ready plus header and data fields.
// No dependencies.
`default_nettype none

interface biv_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] hdr_magic;
    logic [31:0] hdr_size;
    logic [31:0] hdr_crc;
    logic [31:0] stack_pointer;
    logic [31:0] reset_vector;
    logic [7:0]  data_byte;

    modport source (output valid, kind, hdr_magic, hdr_size, hdr_crc, stack_pointer,
                    reset_vector, data_byte, input ready);
    modport sink   (input valid, kind, hdr_magic, hdr_size, hdr_crc, stack_pointer,
                    reset_vector, data_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/biv_out_if.sv -----
// Result channel of the boot image verifier: valid/ready plus verdict fields.
// No dependencies.
`default_nettype none

interface biv_out_if;
    logic        valid;
    logic        ready;
    logic        verdict_kind;
    logic        vector_ok;
    logic        magic_ok;
    logic        header_ok;
    logic        crc_match;
    logic [31:0] crc_value;

    modport source (output valid, verdict_kind, vector_ok, magic_ok, header_ok, crc_match,
                    crc_value, input ready);
    modport sink   (input valid, verdict_kind, vector_ok, magic_ok, header_ok, crc_match,
                    crc_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/boot_image_verifier.sv -----
// Boot image verifier: header checks and streaming reflected CRC-32 of the image.
// Depends on biv_pkg, biv_in_if, biv_out_if and boot_image_verifier_assert.svh.
//
// Usage:
//   in_ch carries items: a header item (kind 0) or one image byte (kind 1).
//   out_ch carries verdicts: a header verdict for every header item, and a
//   final CRC verdict when the byte count reaches the header's image size.
//   Bytes arriving with no valid header armed, or after the image ended,
//   produce nothing. A new header always restarts the check.
//   The APB port holds the region bounds and the expected magic word; write
//   it only while the block is idle. pready is tied high.
//   Throughput: one item per cycle while out_ch takes results. Each item is
//   captured in the input register when accepted, and the combinational
//   check/CRC logic (byte CRC unrolled over eight bits) then loads the
//   result register, from which the verdict is presented on out_ch.
//   When out_ch stalls, the result register holds; the input register still
//   takes one more item, after which in_ch.ready drops until the result is
//   taken.
//   Reset (rst_n low, asynchronous) empties both stages, disarms the check
//   and restores the register defaults.
`default_nettype none

`include "boot_image_verifier_assert.svh"

module boot_image_verifier
    import biv_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    biv_in_if.sink      in_ch,
    biv_out_if.source   out_ch,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [31:0] app_start_reg;
    logic [31:0] app_end_reg;
    logic [31:0] sram_low_reg;
    logic [31:0] sram_high_reg;
    logic [31:0] magic_reg;

    // Input register stage.
    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [31:0] s1_magic_reg;
    logic [31:0] s1_size_reg;
    logic [31:0] s1_crc_reg;
    logic [31:0] s1_sp_reg;
    logic [31:0] s1_rv_reg;
    logic [7:0]  s1_byte_reg;

    // Check state.
    logic [31:0] crc_running_reg, crc_running_next;
    logic [31:0] bytes_seen_reg, bytes_seen_next;
    logic [31:0] image_size_reg, image_size_next;
    logic [31:0] crc_expected_reg, crc_expected_next;
    logic        checking_reg, checking_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic        res_kind_reg;
    logic        res_vector_ok_reg;
    logic        res_magic_ok_reg;
    logic        res_header_ok_reg;
    logic        res_crc_match_reg;
    logic [31:0] res_crc_value_reg;

    logic        advance;
    logic        proc;
    logic        res_load;
    logic        magic_ok;
    logic        size_ok;
    logic        crc_ok;
    logic        header_ok;
    logic        vector_ok;
    logic [32:0] region_sum;
    logic [31:0] crc_new;
    logic [31:0] final_crc;
    logic [31:0] count_inc;
    logic        last_byte;
    logic        cfg_we;
    reg_idx_t    cfg_idx;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            REG_APP_START: prdata = app_start_reg;
            REG_APP_END:   prdata = app_end_reg;
            REG_SRAM_LOW:  prdata = sram_low_reg;
            REG_SRAM_HIGH: prdata = sram_high_reg;
            REG_MAGIC:     prdata = magic_reg;
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            app_start_reg <= APP_START_RST;
            app_end_reg   <= APP_END_RST;
            sram_low_reg  <= SRAM_LOW_RST;
            sram_high_reg <= SRAM_HIGH_RST;
            magic_reg     <= MAGIC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_APP_START: app_start_reg <= pwdata;
                REG_APP_END:   app_end_reg   <= pwdata;
                REG_SRAM_LOW:  sram_low_reg  <= pwdata;
                REG_SRAM_HIGH: sram_high_reg <= pwdata;
                REG_MAGIC:     magic_reg     <= pwdata;
                default:       ;
            endcase
        end
    end

    // Handshake: the work stage moves whenever the result register can take a value.
    assign advance     = !out_valid_reg || out_ch.ready;
    assign proc        = s1_valid_reg && advance;
    assign in_ch.ready = !s1_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_kind_reg  <= in_ch.kind;
            s1_magic_reg <= in_ch.hdr_magic;
            s1_size_reg  <= in_ch.hdr_size;
            s1_crc_reg   <= in_ch.hdr_crc;
            s1_sp_reg    <= in_ch.stack_pointer;
            s1_rv_reg    <= in_ch.reset_vector;
            s1_byte_reg  <= in_ch.data_byte;
        end
    end

    // Header checks.
    assign region_sum = {1'b0, app_start_reg} + {1'b0, s1_size_reg};
    assign magic_ok   = (s1_magic_reg == magic_reg);
    assign size_ok    = (s1_size_reg != 32'd0) && (s1_size_reg != ALL_ONES)
                        && (region_sum <= {1'b0, app_end_reg});
    assign crc_ok     = (s1_crc_reg != ALL_ONES) && (s1_crc_reg != CRC_PLACEHOLDER);
    assign header_ok  = magic_ok && size_ok && crc_ok;
    assign vector_ok  = (s1_sp_reg >= sram_low_reg) && (s1_sp_reg <= sram_high_reg)
                        && (s1_rv_reg >= app_start_reg) && (s1_rv_reg < app_end_reg)
                        && s1_rv_reg[0];

    // Byte update and end-of-image detection.
    assign crc_new   = crc32_byte(crc_running_reg, s1_byte_reg);
    assign final_crc = crc_new ^ ALL_ONES;
    assign count_inc = bytes_seen_reg + 32'd1;
    assign last_byte = (count_inc == image_size_reg);

    assign res_load = proc && ((s1_kind_reg == KIND_HEADER) || (checking_reg && last_byte));

    // Next state of the check.
    always_comb
    begin
        crc_running_next  = crc_running_reg;
        bytes_seen_next   = bytes_seen_reg;
        image_size_next   = image_size_reg;
        crc_expected_next = crc_expected_reg;
        checking_next     = checking_reg;
        if (proc)
        begin
            if (s1_kind_reg == KIND_HEADER)
            begin
                crc_running_next  = ALL_ONES;
                bytes_seen_next   = 32'd0;
                image_size_next   = s1_size_reg;
                crc_expected_next = s1_crc_reg;
                checking_next     = header_ok;
            end
            else if (checking_reg)
            begin
                crc_running_next = crc_new;
                bytes_seen_next  = count_inc;
                if (last_byte)
                    checking_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_running_reg  <= ALL_ONES;
            bytes_seen_reg   <= 32'd0;
            image_size_reg   <= 32'd0;
            crc_expected_reg <= 32'd0;
            checking_reg     <= 1'b0;
        end
        else
        begin
            crc_running_reg  <= crc_running_next;
            bytes_seen_reg   <= bytes_seen_next;
            image_size_reg   <= image_size_next;
            crc_expected_reg <= crc_expected_next;
            checking_reg     <= checking_next;
        end
    end

    // Result register.
    always_comb
    begin
        if (res_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            if (s1_kind_reg == KIND_HEADER)
            begin
                res_kind_reg      <= KIND_HEADER;
                res_vector_ok_reg <= vector_ok;
                res_magic_ok_reg  <= magic_ok;
                res_header_ok_reg <= header_ok;
                res_crc_match_reg <= 1'b0;
                res_crc_value_reg <= 32'd0;
            end
            else
            begin
                res_kind_reg      <= KIND_DATA;
                res_vector_ok_reg <= 1'b0;
                res_magic_ok_reg  <= 1'b0;
                res_header_ok_reg <= 1'b0;
                res_crc_match_reg <= (final_crc == crc_expected_reg);
                res_crc_value_reg <= final_crc;
            end
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.verdict_kind = res_kind_reg;
    assign out_ch.vector_ok    = res_vector_ok_reg;
    assign out_ch.magic_ok     = res_magic_ok_reg;
    assign out_ch.header_ok    = res_header_ok_reg;
    assign out_ch.crc_match    = res_crc_match_reg;
    assign out_ch.crc_value    = res_crc_value_reg;

    // Checks on the control logic.
    `BIV_ASSERT_IMP(a_ready_low_only_when_full, clk, rst_n, !in_ch.ready, s1_valid_reg && out_valid_reg, "input stalled while a stage was free")
    `BIV_ASSERT_IMP(a_count_below_size, clk, rst_n, checking_reg, bytes_seen_reg < image_size_reg, "byte count reached image size while still checking")
    `BIV_ASSERT_NXT(a_final_disarms, clk, rst_n, res_load && (s1_kind_reg == KIND_DATA), !checking_reg, "final verdict left the check armed")
    `BIV_ASSERT_NXT(a_header_arms, clk, rst_n, res_load && (s1_kind_reg == KIND_HEADER) && header_ok, checking_reg && (bytes_seen_reg == 32'd0), "passing header did not arm a fresh check")

endmodule

`default_nettype wire
